// ===== src/double_ended_queue_macros.svh =====
// Assertion macros shared by the deque checker.
// Depends on nothing; the user supplies clock and reset signals in scope.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define DQE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define DQE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/dq_pkg.sv =====
// Shared types and constants of the double-ended queue.
// Used by the controller, the datapath, the top level and the checker.
package dq_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;
   localparam int unsigned OP_W          = 3;
   localparam int unsigned DATA_W        = 32;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned OCC_W         = 5;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_REAR  = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   typedef enum logic {
      CS_IDLE = 1'b0,
      CS_RESP = 1'b1
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic respond;
   } cmd_type;

endpackage

// ===== src/dq_controller.sv =====
// Sequencer of the double-ended queue: accepts a beat, then shows its result.
// Depends on dq_pkg.
module dq_controller (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   output logic            rsp_strobe,
   output dq_pkg::cmd_type cmd
);

   dq_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dq_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      busy        = 1'b0;
      rsp_strobe  = 1'b0;
      cmd.load    = 1'b0;
      cmd.respond = 1'b0;
      case (state_ff)
         dq_pkg::CS_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = dq_pkg::CS_RESP;
            end
         end
         dq_pkg::CS_RESP: begin
            busy        = 1'b1;
            rsp_strobe  = 1'b1;
            cmd.respond = 1'b1;
            state_in    = dq_pkg::CS_IDLE;
         end
         default: begin
            state_in = dq_pkg::CS_IDLE;
         end
      endcase
   end

endmodule

// ===== src/dq_datapath.sv =====
// Ring store, head pointer and count of the double-ended queue.
// Depends on dq_pkg; driven by commands from dq_controller.
module dq_datapath #(
   parameter int unsigned DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dq_pkg::cmd_type               cmd,
   input  logic [dq_pkg::OP_W-1:0]       req_op,
   input  logic signed [dq_pkg::DATA_W-1:0] req_value,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_data,
   output logic [dq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [dq_pkg::OCC_W-1:0]      rsp_occupancy,
   output logic                          rsp_is_empty
);

   localparam int unsigned IdxW = $clog2(DEPTH);
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [CntW:0]   DepthX  = (CntW+1)'(DEPTH);
   localparam logic [CntW-1:0] DepthC  = CntW'(DEPTH);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

   logic signed [dq_pkg::DATA_W-1:0] mem [DEPTH];

   logic [IdxW-1:0] head_ff, head_in;
   logic [CntW-1:0] count_ff, count_in;
   logic signed [dq_pkg::DATA_W-1:0] rd_ff;
   logic            hit_ff, hit;
   dq_pkg::status_type status_ff, status;

   logic            full, empty, wr_en;
   logic [IdxW-1:0] wr_addr, rd_addr;
   logic [IdxW-1:0] head_inc, head_dec, rear_push, rear_slot;
   logic [CntW:0]   sum_push, sum_rear;

   always_comb begin
      full  = (count_ff == DepthC);
      empty = (count_ff == '0);

      head_inc = (head_ff == LastIdx) ? '0 : head_ff + 1'b1;
      head_dec = (head_ff == '0) ? LastIdx : head_ff - 1'b1;

      // head + count and head + count - 1 stay below twice the depth
      sum_push  = (CntW+1)'(head_ff) + (CntW+1)'(count_ff);
      sum_rear  = sum_push - 1'b1;
      rear_push = (sum_push >= DepthX) ? IdxW'(sum_push - DepthX) : IdxW'(sum_push);
      rear_slot = (sum_rear >= DepthX) ? IdxW'(sum_rear - DepthX) : IdxW'(sum_rear);

      head_in  = head_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = head_ff;
      rd_addr  = head_ff;
      hit      = 1'b0;
      status   = dq_pkg::ST_OK;

      case (dq_pkg::op_type'(req_op))
         dq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               status = dq_pkg::ST_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = head_dec;
               head_in  = head_dec;
               count_in = count_ff + 1'b1;
            end
         end
         dq_pkg::OP_PUSH_REAR: begin
            if (full) begin
               status = dq_pkg::ST_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = rear_push;
               count_in = count_ff + 1'b1;
            end
         end
         dq_pkg::OP_POP_FRONT: begin
            if (empty) begin
               status = dq_pkg::ST_UNDERFLOW;
            end else begin
               hit      = 1'b1;
               head_in  = head_inc;
               count_in = count_ff - 1'b1;
            end
         end
         dq_pkg::OP_POP_REAR: begin
            if (empty) begin
               status = dq_pkg::ST_UNDERFLOW;
            end else begin
               hit      = 1'b1;
               rd_addr  = rear_slot;
               count_in = count_ff - 1'b1;
            end
         end
         dq_pkg::OP_PEEK_FRONT: begin
            if (empty) begin
               status = dq_pkg::ST_UNDERFLOW;
            end else begin
               hit = 1'b1;
            end
         end
         dq_pkg::OP_PEEK_REAR: begin
            if (empty) begin
               status = dq_pkg::ST_UNDERFLOW;
            end else begin
               hit     = 1'b1;
               rd_addr = rear_slot;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load && wr_en) begin
         mem[wr_addr] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_ff     <= mem[rd_addr];
         hit_ff    <= hit;
         status_ff <= status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.load) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // zero data unless the beat actually read a word
   assign rsp_data      = (cmd.respond && hit_ff) ? rd_ff : '0;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = dq_pkg::OCC_W'(count_ff);
   assign rsp_is_empty  = (count_ff == '0);

endmodule

// ===== src/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit words kept in a ring store.
// Depends on dq_pkg, dq_controller and dq_datapath.
//
// Request channel: drive req_op and req_value and raise start; the beat is
// taken at the rising edge where start is high and busy is low. Ops are push
// front, push rear, pop front, pop rear, peek front and peek rear.
// Response channel: exactly one response per request, shown for one cycle
// with rsp_strobe high, the cycle right after the request is taken. It holds
// the word read (zero for pushes and underflow), the status (ok, underflow,
// overflow), the occupancy after the op and an empty flag.
// Busy is high during the response cycle, so no new request is taken while
// a response is shown. The response waits on the single registered read
// port of the ring store, read at the accept edge.
// The receiver has no back-pressure: it must take the response when shown.
// Synchronous reset empties the queue (head and count to zero) and returns
// the sequencer to idle; the store itself is not cleared, and no word is
// ever shown from a slot outside the occupied region.
module double_ended_queue #(
   parameter int unsigned DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [dq_pkg::OP_W-1:0]          req_op,
   input  logic signed [dq_pkg::DATA_W-1:0] req_value,
   output logic                             rsp_strobe,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_data,
   output logic [dq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [dq_pkg::OCC_W-1:0]         rsp_occupancy,
   output logic                             rsp_is_empty
);

   dq_pkg::cmd_type cmd;

   dq_controller u_ctl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   dq_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_op        (req_op),
      .req_value     (req_value),
      .rsp_data      (rsp_data),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy),
      .rsp_is_empty  (rsp_is_empty)
   );

endmodule

// ===== src/dq_checker.sv =====
// Port-level checks of the double-ended queue, bound to the top level.
// Depends on dq_pkg and double_ended_queue_macros.svh.
`include "double_ended_queue_macros.svh"

module dq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_strobe,
   input logic signed [dq_pkg::DATA_W-1:0] rsp_data,
   input logic [dq_pkg::STATUS_W-1:0]      rsp_status,
   input logic [dq_pkg::OCC_W-1:0]         rsp_occupancy,
   input logic                             rsp_is_empty
);

   // every accepted beat answers in the next cycle
   `DQE_ASSERT_NEXT(a_accept_resp, start && !busy, rsp_strobe, "accepted beat gave no response")

   `DQE_ASSERT_NEXT(a_single_strobe, rsp_strobe, !rsp_strobe, "response shown twice")

   `DQE_ASSERT_NOW(a_err_zero_data, rsp_strobe && rsp_status != dq_pkg::ST_OK, rsp_data == '0, "error response carries data")

   `DQE_ASSERT_NOW(a_underflow_empty, rsp_strobe && rsp_status == dq_pkg::ST_UNDERFLOW, rsp_is_empty && rsp_occupancy == '0, "underflow on a non-empty queue")

endmodule

bind double_ended_queue dq_checker u_chk (.*);
